[rtl/core/rsot_pkg.sv]
// ============================================================================
// rsot_pkg
// Shared types and constants for the row span occupancy table.
// ============================================================================
package rsot_pkg;

	localparam int ENTRIES  = 64;
	localparam int GRID_DIM = 256;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	// Reset value of the grid size registers, limited to what 9 bits hold.
	localparam logic [8:0] DIM_RESET = (GRID_DIM > 511) ? 9'd511 : 9'(GRID_DIM);

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b1;

	typedef enum logic [1:0] {
		CMD_QUERY  = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_MOVE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		STS_OK      = 3'd0,
		STS_OUTSIDE = 3'd1,
		STS_NO_SPAN = 3'd2,
		STS_OVERLAP = 3'd3,
		STS_FULL    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EVAL
	} state_t;

	typedef struct packed {
		logic [7:0] row;
		logic [7:0] col;
		logic [8:0] len;
	} span_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic             set_valid;
		logic             clr_valid;
		logic [IDX_W-1:0] wr_addr;
		span_t            wr_data;
	} store_req_t;

endpackage

[rtl/core/rsot_store.sv]
// ============================================================================
// rsot_store
// Span entry memory with one read and one write port and per-entry valid bits.
// ============================================================================
module rsot_store (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rsot_pkg::store_req_t req,
	output rsot_pkg::span_t      rd_span,
	output logic                 rd_valid
);
	import rsot_pkg::*;

	span_t              mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	span_t              rd_span_q;
	logic               rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_span_q <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.set_valid) begin
				valid_q[req.wr_addr] <= 1'b1;
			end else if (req.clr_valid) begin
				valid_q[req.wr_addr] <= 1'b0;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_addr];
			end
		end
	end

	assign rd_span  = rd_span_q;
	assign rd_valid = rd_valid_q;

endmodule

[rtl/core/row_span_occupancy_table.sv]
// ============================================================================
// row_span_occupancy_table
// Table of non-overlapping horizontal spans on a configurable grid.
// ============================================================================
// Usage: a command beat is taken when start is high and busy is low. Each
// command gives exactly one result beat, shown for one cycle with done high;
// the receiver cannot stall, so results are never held back.
// A command that fails its grid check answers on the cycle after the beat.
// Otherwise the sequencer sweeps the entry memory once, one entry per cycle
// through its single read port, and done follows the sweep; busy falls as
// done rises, so no new command is taken until such a command is through.
// A move that finds its source sweeps twice, once to find the source and
// once to check the moved span for overlap.
// Configuration uses its own valid/ready channel, always ready; index 0 is
// grid_height and 1 is grid_width; the user must see that they are written
// only while the block is idle, as the block itself does not enforce this.
// Reset clears every valid bit at once and sets both grid sizes to
// GRID_DIM (at most 511); no clearing pass follows.
// ============================================================================
module row_span_occupancy_table (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         cmd,
	input  logic [7:0]                         row,
	input  logic [7:0]                         col,
	input  logic [8:0]                         span_len,
	input  logic [7:0]                         dest_row,
	input  logic [7:0]                         dest_col,
	output logic                               done,
	output logic [2:0]                         status,
	output logic [7:0]                         hit_row,
	output logic [7:0]                         hit_col,
	output logic [8:0]                         hit_len,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rsot_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [8:0]                         cfg_data
);
	import rsot_pkg::*;

	localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(ENTRIES);

	state_t           state_q, state_d;
	cmd_t             cmd_q;
	logic [7:0]       row_q, col_q, drow_q, dcol_q;
	logic [8:0]       len_q;
	logic [8:0]       height_q, width_q;
	logic             pass_q;
	logic [CNT_W-1:0] cnt_q;
	logic             cmp_en_s1;
	logic             found_q;
	logic [IDX_W-1:0] found_idx_q;
	span_t            found_span_q;
	logic             ovl_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic             done_q;
	status_t          status_q;
	logic [7:0]       hit_row_q, hit_col_q;
	logic [8:0]       hit_len_q;

	store_req_t       mem_req;
	span_t            ent;
	logic             ent_v;

	logic             issue;
	logic             load, scan_go, pass_go, emit;
	status_t          emit_status;
	logic             emit_hits;

	logic             cell_out, dest_out, ins_out, grid_err;
	logic [9:0]       ins_end;
	logic [9:0]       ent_end;
	logic [7:0]       ovl_row, ovl_col;
	logic [8:0]       ovl_len;
	logic [9:0]       ovl_end;
	logic             src_hit, ovl_hit, free_hit;

	rsot_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (mem_req),
		.rd_span  (ent),
		.rd_valid (ent_v)
	);

	// Grid checks on the command beat itself.
	always_comb begin
		ins_end  = {2'b00, col} + {1'b0, span_len};
		cell_out = ({1'b0, row} >= height_q) || ({1'b0, col} >= width_q);
		dest_out = ({1'b0, dest_row} >= height_q) || ({1'b0, dest_col} >= width_q);
		ins_out  = (span_len == 9'd0) || ({1'b0, row} >= height_q) ||
			(ins_end > {1'b0, width_q});
		case (cmd_t'(cmd))
			CMD_INSERT: grid_err = ins_out;
			CMD_MOVE:   grid_err = cell_out || dest_out;
			default:    grid_err = cell_out;
		endcase
	end

	// Per-entry compare on the registered read data.
	always_comb begin
		ent_end  = {2'b00, ent.col} + {1'b0, ent.len};
		ovl_row  = pass_q ? drow_q : row_q;
		ovl_col  = pass_q ? dcol_q : col_q;
		ovl_len  = pass_q ? found_span_q.len : len_q;
		ovl_end  = {2'b00, ovl_col} + {1'b0, ovl_len};
		src_hit  = cmp_en_s1 && ent_v && (ent.row == row_q) && (col_q >= ent.col) &&
			({2'b00, col_q} < ent_end);
		ovl_hit  = cmp_en_s1 && ent_v && (ent.row == ovl_row) &&
			({2'b00, ent.col} < ovl_end) && ({2'b00, ovl_col} < ent_end);
		free_hit = cmp_en_s1 && !ent_v;
	end

	assign issue = (state_q == ST_SCAN) && (cnt_q < ENTRIES_C);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		mem_req     = '0;
		load        = 1'b0;
		scan_go     = 1'b0;
		pass_go     = 1'b0;
		emit        = 1'b0;
		emit_status = STS_OK;
		emit_hits   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (grid_err) begin
						emit        = 1'b1;
						emit_status = STS_OUTSIDE;
					end else begin
						load    = 1'b1;
						scan_go = 1'b1;
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				mem_req.rd_en   = issue;
				mem_req.rd_addr = cnt_q[IDX_W-1:0];
				if (cnt_q == ENTRIES_C) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_d = ST_IDLE;
				case (cmd_q)
					CMD_QUERY: begin
						emit        = 1'b1;
						emit_status = found_q ? STS_OK : STS_NO_SPAN;
						emit_hits   = found_q;
					end
					CMD_INSERT: begin
						emit = 1'b1;
						if (ovl_q) begin
							emit_status = STS_OVERLAP;
						end else if (!free_q) begin
							emit_status = STS_FULL;
						end else begin
							mem_req.wr_en     = 1'b1;
							mem_req.set_valid = 1'b1;
							mem_req.wr_addr   = free_idx_q;
							mem_req.wr_data   = '{row: row_q, col: col_q, len: len_q};
						end
					end
					CMD_DELETE: begin
						emit = 1'b1;
						if (found_q) begin
							mem_req.clr_valid = 1'b1;
							mem_req.wr_addr   = found_idx_q;
						end else begin
							emit_status = STS_NO_SPAN;
						end
					end
					CMD_MOVE: begin
						if (!pass_q) begin
							if (found_q) begin
								scan_go = 1'b1;
								pass_go = 1'b1;
								state_d = ST_SCAN;
							end else begin
								emit        = 1'b1;
								emit_status = STS_NO_SPAN;
							end
						end else begin
							emit = 1'b1;
							if (ovl_q) begin
								emit_status = STS_OVERLAP;
							end else begin
								mem_req.wr_en   = 1'b1;
								mem_req.wr_addr = found_idx_q;
								mem_req.wr_data = '{row: drow_q, col: dcol_q,
									len: found_span_q.len};
							end
						end
					end
					default: begin
						emit = 1'b1;
					end
				endcase
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Command fields, held for the whole command; also the found and free entry indices and the result fields.
	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q  <= cmd_t'(cmd);
			row_q  <= row;
			col_q  <= col;
			len_q  <= span_len;
			drow_q <= dest_row;
			dcol_q <= dest_col;
		end
		cmp_idx_s1 <= cnt_q[IDX_W-1:0];
		if (src_hit && !found_q && !pass_q) begin
			found_idx_q  <= cmp_idx_s1;
			found_span_q <= ent;
		end
		if (free_hit && !free_q) begin
			free_idx_q <= cmp_idx_s1;
		end
		if (emit) begin
			status_q  <= emit_status;
			hit_row_q <= emit_hits ? found_span_q.row : 8'd0;
			hit_col_q <= emit_hits ? found_span_q.col : 8'd0;
			hit_len_q <= emit_hits ? found_span_q.len : 9'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q  <= DIM_RESET;
			width_q   <= DIM_RESET;
			pass_q    <= 1'b0;
			cnt_q     <= '0;
			cmp_en_s1 <= 1'b0;
			found_q   <= 1'b0;
			ovl_q     <= 1'b0;
			free_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_GRID_HEIGHT) begin
					height_q <= cfg_data;
				end else if (cfg_index == REG_GRID_WIDTH) begin
					width_q <= cfg_data;
				end
			end
			cmp_en_s1 <= issue;
			done_q    <= emit;
			if (scan_go) begin
				cnt_q  <= '0;
				ovl_q  <= 1'b0;
				free_q <= 1'b0;
			end else begin
				if (issue) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (ovl_hit) begin
					ovl_q <= 1'b1;
				end
				if (free_hit) begin
					free_q <= 1'b1;
				end
			end
			if (load) begin
				found_q <= 1'b0;
				pass_q  <= 1'b0;
			end else begin
				if (pass_go) begin
					pass_q <= 1'b1;
				end
				if (src_hit && !pass_q) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign status    = status_q;
	assign hit_row   = hit_row_q;
	assign hit_col   = hit_col_q;
	assign hit_len   = hit_len_q;

`ifndef SYNTH
	// Every accepted command is either in flight or answered on the next cycle.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted command neither started nor answered");

	// Failed commands never report a span.
	a_hit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != STS_OK)) |-> (hit_len == 9'd0))
		else $error("hit fields set on a failed command");

	// The entry memory is only changed once a sweep has finished.
	a_write_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.wr_en || mem_req.set_valid || mem_req.clr_valid) |->
		(state_q == ST_EVAL && !mem_req.rd_en))
		else $error("entry memory written during a sweep");

	// A result never appears while the sequencer still has work to do.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == ST_IDLE))
		else $error("result shown while busy");
`endif

endmodule
